// ===== hdl/vfr_pkg.sv =====
// ----------------------------------------------------------------------------
// vfr_pkg
// Types and constants shared by the vertex first-use reindex core.
// ----------------------------------------------------------------------------
package vfr_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int IDX_W        = 12;
	localparam int SLOT_W       = 13;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int EPOCH_W      = 8;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	typedef struct packed {
		logic [IDX_W-1:0] vert_index;
		logic             last_of_mesh;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] new_index;
		logic [IDX_W-1:0] source_index;
		logic             first_use;
		logic             mesh_done;
	} result_t;

	// table entry: mesh epoch of the write, slot assigned in that mesh
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [IDX_W-1:0]   slot;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/vfr_ram.sv =====
// ----------------------------------------------------------------------------
// vfr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/vertex_first_use_reindex_core.sv =====
// ----------------------------------------------------------------------------
// vertex_first_use_reindex_core
// Renumbers a stream of vertex indices in order of first use.
// ----------------------------------------------------------------------------
// One index per transaction, one result per index, on the result ports for a
// single cycle (result_valid) after the stage-1 register (valid_s1) and the
// result register; the receiver cannot stall, so every result must be taken
// when shown. While running and not busy, a new index is accepted every cycle:
// each index costs one read-modify-write of the slot table RAM, with the write
// of the previous index forwarded to the next read. Table entries carry a mesh
// epoch, so ending a mesh costs nothing, except that busy goes high when the
// last index of every 255th mesh reaches stage 1 and stays high while the
// table is swept clean. The same sweep runs after reset before the first
// index.
// ----------------------------------------------------------------------------
module vertex_first_use_reindex_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vfr_pkg::item_t   item,
	output logic             result_valid,
	output vfr_pkg::result_t result
);

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	state_t state_q;

	logic [vfr_pkg::ADDR_W-1:0]  clear_addr_q;
	logic [vfr_pkg::EPOCH_W-1:0] epoch_q;
	logic [vfr_pkg::SLOT_W-1:0]  next_slot_q;

	logic                        valid_s1;
	logic [vfr_pkg::IDX_W-1:0]   idx_s1;
	logic                        last_s1;

	logic                        fwd_valid_q;
	logic [vfr_pkg::ADDR_W-1:0]  fwd_addr_q;
	vfr_pkg::entry_t             fwd_data_q;

	vfr_pkg::result_t            result_q;

	logic                        accept;
	logic                        wrap;
	vfr_pkg::entry_t             ram_rdata;
	vfr_pkg::entry_t             cur;
	logic                        in_range;
	logic                        seen;
	logic                        take_slot;
	logic [vfr_pkg::IDX_W-1:0]   slot;

	logic                        ram_we;
	logic [vfr_pkg::ADDR_W-1:0]  ram_waddr;
	vfr_pkg::entry_t             ram_wdata;

	assign wrap   = valid_s1 && last_s1 && (epoch_q == vfr_pkg::EPOCH_LAST);
	assign busy   = (state_q == ST_CLEAR) || wrap;
	assign accept = start && !busy;

	always_comb begin
		cur = ram_rdata;
		if (fwd_valid_q && (fwd_addr_q == idx_s1[vfr_pkg::ADDR_W-1:0])) begin
			cur = fwd_data_q;
		end
	end

	always_comb begin
		in_range  = 32'(idx_s1) < vfr_pkg::MAX_VERTICES;
		seen      = (cur.epoch == epoch_q);
		take_slot = 1'b0;
		slot      = '0;
		if (in_range) begin
			if (seen) begin
				slot = cur.slot;
			end else if (32'(next_slot_q) < vfr_pkg::MAX_VERTICES) begin
				take_slot = 1'b1;
				slot      = next_slot_q[vfr_pkg::IDX_W-1:0];
			end
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clear_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we          = valid_s1 && take_slot;
			ram_waddr       = idx_s1[vfr_pkg::ADDR_W-1:0];
			ram_wdata.epoch = epoch_q;
			ram_wdata.slot  = slot;
		end
	end

	vfr_ram #(
		.WIDTH(vfr_pkg::ENTRY_W),
		.DEPTH(vfr_pkg::MAX_VERTICES)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (item.vert_index[vfr_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clear_addr_q <= '0;
			epoch_q      <= vfr_pkg::EPOCH_FIRST;
			next_slot_q  <= '0;
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= accept;
			result_valid <= valid_s1;
			unique case (state_q)
				ST_CLEAR: begin
					fwd_valid_q  <= 1'b0;
					clear_addr_q <= clear_addr_q + 1'b1;
					if (clear_addr_q == vfr_pkg::ADDR_W'(vfr_pkg::MAX_VERTICES - 1)) begin
						state_q <= ST_RUN;
						epoch_q <= vfr_pkg::EPOCH_FIRST;
					end
				end
				ST_RUN: begin
					fwd_valid_q <= ram_we;
					if (valid_s1) begin
						if (last_s1) begin
							next_slot_q <= '0;
							if (wrap) begin
								state_q      <= ST_CLEAR;
								clear_addr_q <= '0;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
						end else if (take_slot) begin
							next_slot_q <= next_slot_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= item.vert_index;
			last_s1 <= item.last_of_mesh;
		end
		if (ram_we) begin
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
		if (valid_s1) begin
			result_q.new_index    <= slot;
			result_q.source_index <= idx_s1;
			result_q.first_use    <= take_slot;
			result_q.mesh_done    <= last_s1;
		end
	end

	assign result = result_q;

	// no transaction is taken while the table sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !accept)
		else $error("transaction accepted during table clear");

	// a fresh slot is the counter value before the increment
	a_fresh_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.first_use && !result.mesh_done) |->
		(next_slot_q == vfr_pkg::SLOT_W'($past(next_slot_q) + 1'b1)) &&
		(result.new_index == $past(next_slot_q[vfr_pkg::IDX_W-1:0])))
		else $error("fresh slot does not match counter");

	// ending a mesh leaves the counter at zero
	a_mesh_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mesh_done) |-> (next_slot_q == '0))
		else $error("counter not cleared at mesh end");

	// the cleared epoch is never the live one
	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("live epoch is zero");

	// every accepted transaction is followed by a result
	a_result_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 result_valid)
		else $error("result missing after accepted transaction");

endmodule
